// ===== rtl/effect_slot_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// effect_slot_allocator_assert.svh
// Assertion macros used by the effect slot allocator controller.
// ----------------------------------------------------------------------------
`ifndef EFFECT_SLOT_ALLOCATOR_ASSERT_SVH
`define EFFECT_SLOT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
// property checked on every clock edge outside reset
`define ESA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen outside reset
`define ESA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ESA_ASSERT(lbl, prop, msg)
`define ESA_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/esa_pkg.sv =====
// ----------------------------------------------------------------------------
// esa_pkg
// Types, codes and constants of the effect slot allocator.
// ----------------------------------------------------------------------------
package esa_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic [CNT_W-1:0] SLOTS_C    = CNT_W'(SLOTS);
  localparam logic [7:0]       SLOTS_IDX  = 8'(SLOTS);
  localparam logic [7:0]       FREE_ALL_IDX = 8'd255;

  localparam logic [15:0] POOL_CAP_RST  = 16'd4096;
  localparam logic [15:0] SLOT_COST_RST = 16'd256;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_CAPACITY = 1'b0,
    CFG_SLOT_COST     = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    K_CREATE   = 4'd0,
    K_START    = 4'd1,
    K_SOLO     = 4'd2,
    K_STOP     = 4'd3,
    K_FREE     = 4'd4,
    K_FREE_ALL = 4'd5,
    K_STOP_ALL = 4'd6,
    K_PAUSE    = 4'd7,
    K_RESUME   = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_CREATED = 2'd1,
    STS_FULL    = 2'd2,
    STS_BAD     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SS_FREE  = 2'd0,
    SS_ALLOC = 2'd1,
    SS_PLAY  = 2'd2
  } slot_st_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP0,
    ST_SWEEP,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] slot_index;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  given_slot;
    status_t     status;
    logic [15:0] pool_left;
    logic        paused;
  } res_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_st_t          wr_data;
    logic              clr_all;
  } mem_req_t;

endpackage

// ===== rtl/esa_slot_mem.sv =====
// ----------------------------------------------------------------------------
// esa_slot_mem
// Slot status memory, one read and one write port, registered read data.
// Per-entry valid bits make cleared entries read as free.
// ----------------------------------------------------------------------------
module esa_slot_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  esa_pkg::mem_req_t req,
  output esa_pkg::slot_st_t rd_data
);
  import esa_pkg::*;

  slot_st_t   mem [SLOTS];
  logic       vld_r [SLOTS];
  slot_st_t   rd_data_r;
  logic       rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr_all) begin
      for (int i = 0; i < SLOTS; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  // write to the entry being read is forwarded
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
        rd_data_r <= req.wr_data;
        rd_vld_r  <= 1'b1;
      end else begin
        rd_data_r <= mem[req.rd_addr];
        rd_vld_r  <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : SS_FREE;

endmodule

// ===== rtl/esa_ctrl.sv =====
// ----------------------------------------------------------------------------
// esa_ctrl
// Command sequencer: decodes requests, runs read-modify-write on the slot
// memory, scans for the next free slot, sweeps for stop all and solo start, keeps the pool.
// ----------------------------------------------------------------------------
module esa_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [esa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  esa_pkg::in_req_t                in_data,
  output logic                            res_valid,
  input  logic                            res_ready,
  output esa_pkg::res_t                   res_data,
  output esa_pkg::mem_req_t               mem_req,
  input  esa_pkg::slot_st_t               mem_rd_data
);
  import esa_pkg::*;

  `include "effect_slot_allocator_assert.svh"

  state_t           state_r, state_nxt;
  logic [3:0]       kind_r, kind_nxt;
  logic [7:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0] nf_r, nf_nxt;
  logic [CNT_W-1:0] p_r, p_nxt;
  logic [15:0]      pool_r, pool_nxt;
  logic             pause_r, pause_nxt;
  logic [15:0]      cap_r, cost_r;
  logic [3:0]       given_r, given_nxt;
  status_t          status_r, status_nxt;

  logic             nf_full, idx_ok, scan_hit;
  logic [CNT_W-1:0] nf_inc, p_inc, p_dec;
  logic [SLOT_W-1:0] idx_addr;
  logic [16:0]      credit_sum;

  assign nf_full    = (nf_r == SLOTS_C);
  assign idx_ok     = (idx_r != 8'd0) && (idx_r < SLOTS_IDX);
  assign nf_inc     = nf_r + 1'b1;
  assign p_inc      = p_r + 1'b1;
  assign p_dec      = p_r - 1'b1;
  assign idx_addr   = idx_r[SLOT_W-1:0];
  assign scan_hit   = (mem_rd_data == SS_FREE);
  assign credit_sum = {1'b0, pool_r} + {1'b0, cost_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (kind_r)
          K_CREATE: begin
            state_nxt = (nf_full || (nf_inc == SLOTS_C)) ? ST_DONE : ST_SCAN;
          end
          K_START, K_STOP: state_nxt = idx_ok ? ST_READ : ST_DONE;
          K_SOLO:          state_nxt = idx_ok ? ST_SWEEP0 : ST_DONE;
          K_FREE: begin
            state_nxt = ((idx_r != FREE_ALL_IDX) && idx_ok) ? ST_READ : ST_DONE;
          end
          K_STOP_ALL:      state_nxt = ST_SWEEP0;
          default:         state_nxt = ST_DONE;
        endcase
      end
      ST_SWEEP0: state_nxt = ST_SWEEP;
      ST_SWEEP: begin
        if (p_r == SLOTS_C) state_nxt = (kind_r == K_SOLO) ? ST_READ : ST_DONE;
      end
      ST_READ: state_nxt = ST_DONE;
      ST_SCAN: begin
        if (scan_hit || (p_inc == SLOTS_C)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: handshakes and memory port
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    res_valid = (state_r == ST_DONE);
    mem_req   = '{rd_en: 1'b0, rd_addr: '0, wr_en: 1'b0, wr_addr: '0,
                  wr_data: SS_FREE, clr_all: 1'b0};
    case (state_r)
      ST_EXEC: begin
        case (kind_r)
          K_CREATE: begin
            if (!nf_full) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = nf_r[SLOT_W-1:0];
              mem_req.wr_data = SS_ALLOC;
              if (nf_inc != SLOTS_C) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = nf_inc[SLOT_W-1:0];
              end
            end
          end
          K_START, K_STOP: begin
            mem_req.rd_en   = idx_ok;
            mem_req.rd_addr = idx_addr;
          end
          K_FREE: begin
            if (idx_r == FREE_ALL_IDX) begin
              mem_req.clr_all = 1'b1;
            end else begin
              mem_req.rd_en   = idx_ok;
              mem_req.rd_addr = idx_addr;
            end
          end
          K_FREE_ALL: mem_req.clr_all = 1'b1;
          default: ;
        endcase
      end
      ST_SWEEP0: begin
        mem_req.rd_en = 1'b1;
      end
      ST_SWEEP: begin
        // data of entry p-1 is back; read entry p
        if (mem_rd_data == SS_PLAY) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = p_dec[SLOT_W-1:0];
          mem_req.wr_data = SS_ALLOC;
        end
        if (p_r != SLOTS_C) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = p_r[SLOT_W-1:0];
        end else if (kind_r == K_SOLO) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_addr;
        end
      end
      ST_READ: begin
        mem_req.wr_addr = idx_addr;
        case (kind_r)
          K_START, K_SOLO: begin
            mem_req.wr_en   = (mem_rd_data != SS_FREE);
            mem_req.wr_data = SS_PLAY;
          end
          K_STOP: begin
            mem_req.wr_en   = (mem_rd_data == SS_PLAY);
            mem_req.wr_data = SS_ALLOC;
          end
          K_FREE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = SS_FREE;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (!scan_hit && (p_inc != SLOTS_C)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = p_inc[SLOT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    kind_nxt   = kind_r;
    idx_nxt    = idx_r;
    nf_nxt     = nf_r;
    p_nxt      = p_r;
    pool_nxt   = pool_r;
    pause_nxt  = pause_r;
    given_nxt  = given_r;
    status_nxt = status_r;
    case (state_r)
      ST_IDLE: begin
        kind_nxt = in_data.kind;
        idx_nxt  = in_data.slot_index;
      end
      ST_EXEC: begin
        given_nxt  = 4'd0;
        status_nxt = STS_DONE;
        case (kind_r)
          K_CREATE: begin
            if (nf_full) begin
              status_nxt = STS_FULL;
            end else begin
              given_nxt  = 4'(nf_r);
              status_nxt = STS_CREATED;
              pool_nxt   = (pool_r >= cost_r) ? (pool_r - cost_r) : 16'd0;
              if (nf_inc == SLOTS_C) nf_nxt = SLOTS_C;
              else p_nxt = nf_inc;
            end
          end
          K_START, K_SOLO, K_STOP: begin
            if (!idx_ok) status_nxt = STS_BAD;
          end
          K_FREE: begin
            if (idx_r == FREE_ALL_IDX) begin
              nf_nxt   = CNT_W'(1);
              pool_nxt = cap_r;
            end else if (!idx_ok) begin
              status_nxt = STS_BAD;
            end
          end
          K_FREE_ALL: begin
            nf_nxt   = CNT_W'(1);
            pool_nxt = cap_r;
          end
          K_PAUSE:  pause_nxt = 1'b1;
          K_RESUME: pause_nxt = 1'b0;
          default: ;
        endcase
      end
      ST_SWEEP0: p_nxt = CNT_W'(1);
      ST_SWEEP: begin
        if (p_r != SLOTS_C) p_nxt = p_inc;
      end
      ST_READ: begin
        if (kind_r == K_FREE) begin
          if (mem_rd_data != SS_FREE) begin
            pool_nxt = (credit_sum > {1'b0, cap_r}) ? cap_r : credit_sum[15:0];
          end
          if (idx_r < 8'(nf_r)) nf_nxt = CNT_W'(idx_r);
        end
      end
      ST_SCAN: begin
        if (scan_hit) nf_nxt = p_r;
        else if (p_inc == SLOTS_C) nf_nxt = SLOTS_C;
        else p_nxt = p_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      nf_r    <= CNT_W'(1);
      pool_r  <= POOL_CAP_RST;
      pause_r <= 1'b0;
      cap_r   <= POOL_CAP_RST;
      cost_r  <= SLOT_COST_RST;
    end else begin
      state_r <= state_nxt;
      nf_r    <= nf_nxt;
      pool_r  <= pool_nxt;
      pause_r <= pause_nxt;
      if (cfg_we && (cfg_index == CFG_POOL_CAPACITY)) cap_r  <= cfg_wdata;
      if (cfg_we && (cfg_index == CFG_SLOT_COST))     cost_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    idx_r    <= idx_nxt;
    p_r      <= p_nxt;
    given_r  <= given_nxt;
    status_r <= status_nxt;
  end

  assign res_data = '{given_slot: given_r, status: status_r,
                      pool_left: pool_r, paused: pause_r};

  `ESA_NEVER(a_sweep_only_demotes, (state_r == ST_SWEEP) && mem_req.wr_en && (mem_req.wr_data != SS_ALLOC), "stop-all sweep wrote a state other than allocated")
  `ESA_ASSERT(a_next_free_range, (nf_r >= CNT_W'(1)) && (nf_r <= SLOTS_C), "next-free pointer out of range")
  `ESA_ASSERT(a_one_request, (in_valid && in_ready) |=> !in_ready, "second request taken while one is in flight")
  `ESA_NEVER(a_clear_with_access, mem_req.clr_all && (mem_req.rd_en || mem_req.wr_en), "table clear overlaps a slot access")

endmodule

// ===== rtl/effect_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// effect_slot_allocator
// Lowest-free effect slot allocator with memory pool accounting.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    in_data  (kind, slot_index)
//   out      out  out_valid/out_ready  out_data (given_slot, status, pool_left,
//                                               paused)
//   cfg      in   cfg_we               cfg_index, cfg_wdata
//
// One request at a time, from accept to result. Create scans for the next
// free slot, one memory read per cycle; stop all and solo start sweep every
// entry of the slot table.
// A result waits in the output register while the next request is accepted.
// Reset is synchronous; the slot table clears at once through valid bits.
// ----------------------------------------------------------------------------
module effect_slot_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [esa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  esa_pkg::in_req_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output esa_pkg::res_t                 out_data
);
  import esa_pkg::*;

  mem_req_t mem_req;
  slot_st_t mem_rd_data;
  logic     res_valid, res_ready;
  res_t     res_data;
  logic     out_valid_r, out_valid_nxt;
  res_t     out_data_r;

  esa_slot_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  esa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) out_valid_nxt = res_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_data_r <= res_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the effect slot allocator. Requests go in through
// a queue-fed driver with random gaps. Every accepted request is run through
// a behavioral slot table, pool and pause model, and the expected result is
// queued. The monitor compares each result field by field, in order. The
// run steps through several pool/cost settings, extremes included, and
// holds off the result side once long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import esa_pkg::*;

  localparam int RAND_PER_SET = 200;
  localparam int N_SETS       = 5;
  localparam int HOLD_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = CFG_POOL_CAPACITY;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_req_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  res_t        out_data;

  effect_slot_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // behavioral copy of the allocator state
  slot_st_t    slot_tbl [SLOTS];
  int unsigned nxt_free;
  logic [15:0] pool_avail;
  logic [15:0] pool_cap;
  logic [15:0] slot_cost;
  logic        dev_paused;

  in_req_t     pending_reqs [$];
  res_t        due_results [$];
  int unsigned n_sent = 0;
  int unsigned n_res = 0;
  int unsigned n_err = 0;
  int unsigned n_created = 0;
  int unsigned n_full = 0;
  int unsigned n_bad = 0;
  logic        in_took = 1'b0;
  int unsigned hold_left = 0;
  bit          held = 1'b0;

  function automatic void clear_slots();
    for (int i = 0; i < SLOTS; i++) slot_tbl[i] = SS_FREE;
    nxt_free = 1;
    pool_avail = pool_cap;
  endfunction

  function automatic void stop_playing();
    for (int i = 0; i < SLOTS; i++)
      if (slot_tbl[i] == SS_PLAY) slot_tbl[i] = SS_ALLOC;
  endfunction

  // applies one request to the state and returns the result it should give
  function automatic res_t exec_request(in_req_t rq);
    res_t        r;
    int unsigned idx;
    bit          ok;
    logic [16:0] sum;
    r = '0;
    r.status = STS_DONE;
    idx = rq.slot_index;
    ok = (idx >= 1) && (idx < SLOTS);
    case (rq.kind)
      K_CREATE: begin
        if (nxt_free >= SLOTS) begin
          r.status = STS_FULL;
        end else begin
          slot_tbl[nxt_free] = SS_ALLOC;
          r.given_slot = 4'(nxt_free);
          r.status = STS_CREATED;
          pool_avail = (pool_avail >= slot_cost) ? pool_avail - slot_cost : 16'd0;
          while (nxt_free < SLOTS && slot_tbl[nxt_free] != SS_FREE) nxt_free++;
        end
      end
      K_START, K_SOLO: begin
        if (!ok) begin
          r.status = STS_BAD;
        end else begin
          if (rq.kind == K_SOLO) stop_playing();
          if (slot_tbl[idx] != SS_FREE) slot_tbl[idx] = SS_PLAY;
        end
      end
      K_STOP: begin
        if (!ok) r.status = STS_BAD;
        else if (slot_tbl[idx] == SS_PLAY) slot_tbl[idx] = SS_ALLOC;
      end
      K_FREE: begin
        if (rq.slot_index == FREE_ALL_IDX) begin
          clear_slots();
        end else if (!ok) begin
          r.status = STS_BAD;
        end else begin
          // credit only a slot that was in use, capped at capacity
          if (slot_tbl[idx] != SS_FREE) begin
            sum = {1'b0, pool_avail} + {1'b0, slot_cost};
            pool_avail = (sum > {1'b0, pool_cap}) ? pool_cap : sum[15:0];
          end
          slot_tbl[idx] = SS_FREE;
          if (idx < nxt_free) nxt_free = idx;
        end
      end
      K_FREE_ALL: clear_slots();
      K_STOP_ALL: stop_playing();
      K_PAUSE:    dev_paused = 1'b1;
      K_RESUME:   dev_paused = 1'b0;
      default: ;
    endcase
    r.pool_left = pool_avail;
    r.paused = dev_paused;
    return r;
  endfunction

  function automatic in_req_t rand_req();
    in_req_t     r;
    int unsigned pick;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 85) r.slot_index = 8'($urandom_range(SLOTS - 1, 1));
    else r.slot_index = 8'($urandom_range(255));
    if (pick < 30) r.kind = K_CREATE;
    else if (pick < 45) r.kind = K_START;
    else if (pick < 52) r.kind = K_SOLO;
    else if (pick < 62) r.kind = K_STOP;
    else if (pick < 80) r.kind = K_FREE;
    else if (pick < 82) r.kind = K_FREE_ALL;
    else if (pick < 84) begin
      r.kind = K_FREE;
      r.slot_index = FREE_ALL_IDX;
    end
    else if (pick < 87) r.kind = K_STOP_ALL;
    else if (pick < 90) r.kind = K_PAUSE;
    else if (pick < 93) r.kind = K_RESUME;
    else r.kind = 4'($urandom_range(15, 9));
    return r;
  endfunction

  function automatic void push_req(logic [3:0] k, int unsigned idx);
    in_req_t r;
    r.kind = k;
    r.slot_index = 8'(idx);
    pending_reqs.push_back(r);
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_POOL_CAPACITY) pool_cap = val;
    else slot_cost = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || due_results.size() > 0);
  endtask

  task automatic report(string name, logic [15:0] want, logic [15:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    n_err++;
  endtask

  // request driver
  always @(negedge clk) begin : drv
    bit go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      go = (pending_reqs.size() > 0) &&
           ((n_sent >= 400 && n_sent < 600) || $urandom_range(99) >= 19);
      if (go) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side ready, with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (n_res >= 300 && !held) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (n_res >= 400 && n_res < 600) || $urandom_range(99) >= 19;
    end
  end

  // monitor: predict on accept, check on result
  always @(posedge clk) begin : mon
    res_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        due_results.push_back(exec_request(in_data));
        n_sent++;
      end
      if (out_valid && out_ready) begin
        n_res++;
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing expected, got %p", $time, out_data);
          n_err++;
        end else begin
          want = due_results.pop_front();
          if (want.status == STS_CREATED) n_created++;
          if (want.status == STS_FULL) n_full++;
          if (want.status == STS_BAD) n_bad++;
          if (out_data.given_slot !== want.given_slot)
            report("given_slot", 16'(want.given_slot), 16'(out_data.given_slot));
          if (out_data.status !== want.status)
            report("status", 16'(want.status), 16'(out_data.status));
          if (out_data.pool_left !== want.pool_left)
            report("pool_left", want.pool_left, out_data.pool_left);
          if (out_data.paused !== want.paused)
            report("paused", 16'(want.paused), 16'(out_data.paused));
        end
      end
    end
  end

  initial begin
    logic [15:0] caps [N_SETS];
    logic [15:0] costs [N_SETS];
    caps  = '{16'd4096, 16'hFFFF, 16'd0, 16'd1000, 16'd0};
    costs = '{16'd256, 16'hFFFF, 16'd0, 16'd300, 16'd0};
    caps[N_SETS-1]  = 16'($urandom_range(65535));
    costs[N_SETS-1] = 16'($urandom_range(65535));

    pool_cap = POOL_CAP_RST;
    slot_cost = SLOT_COST_RST;
    dev_paused = 1'b0;
    clear_slots();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < N_SETS; p++) begin
      write_reg(CFG_POOL_CAPACITY, caps[p]);
      write_reg(CFG_SLOT_COST, costs[p]);
      if (p == 0) begin
        // fill the table, then one more create on a full table
        for (int i = 0; i < SLOTS; i++) push_req(K_CREATE, 8'($urandom_range(255)));
        push_req(K_START, 3);
        push_req(K_SOLO, 5);
        push_req(K_STOP, 3);      // no longer playing
        push_req(K_STOP, 5);
        push_req(K_FREE, 4);
        push_req(K_FREE, 4);      // already free, no credit
        push_req(K_SOLO, 0);      // bad index, nothing stopped
        push_req(K_STOP, SLOTS);
        push_req(K_FREE, FREE_ALL_IDX);
        push_req(K_PAUSE, 255);
        push_req(K_RESUME, 0);
        push_req(4'd12, 7);
      end
      repeat (RAND_PER_SET) pending_reqs.push_back(rand_req());
      drain();
    end

    repeat (SLOTS + 10) @(negedge clk);
    $display("%0d requests over %0d pool/cost settings, %0d results checked",
             n_sent, N_SETS, n_res);
    $display("%0d creates, %0d full-table, %0d bad-index results, %0d mismatches",
             n_created, n_full, n_bad, n_err);
    if (n_err == 0 && due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
